>>> hdl/mbcm_pkg.sv
// Shared types and constants for the multi-branch class matcher.
package mbcm_pkg;

    // Field widths of the item and result channels
    localparam int ACTION_BITS   = 2;
    localparam int BYTE_BITS     = 8;
    localparam int BRANCH_BITS   = 2;
    localparam int POSITION_BITS = 4;
    localparam int LENGTH_BITS   = 5;
    localparam int START_BITS    = 32;

    // One class store entry per byte value
    localparam int BYTE_VALUES   = 256;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SCAN   = 2'd0,
        ACT_MEMBER = 2'd1,
        ACT_LENGTH = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

endpackage

>>> hdl/mbcm_if.sv
// Valid/ready channel interfaces for items and results of the class matcher.
interface mbcm_in_if import mbcm_pkg::*;
(
);
    logic                     valid;
    logic                     ready;
    logic [ACTION_BITS-1:0]   action;
    logic [BYTE_BITS-1:0]     data_byte;
    logic                     last_byte;
    logic [BRANCH_BITS-1:0]   branch;
    logic [POSITION_BITS-1:0] position_index;
    logic [LENGTH_BITS-1:0]   length;

    modport source
    (
        output valid, action, data_byte, last_byte, branch, position_index, length,
        input  ready
    );

    modport sink
    (
        input  valid, action, data_byte, last_byte, branch, position_index, length,
        output ready
    );
endinterface

interface mbcm_out_if import mbcm_pkg::*;
(
);
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [START_BITS-1:0] start_offset;

    modport source
    (
        output valid, found, start_offset,
        input  ready
    );

    modport sink
    (
        input  valid, found, start_offset,
        output ready
    );
endinterface

>>> hdl/mbcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/mbcm_cell.sv
// One branch cell: holds the branch length and shift-and vector, merges its match into the chain.
module mbcm_cell import mbcm_pkg::*;
#(
    parameter int MAX_LENGTH  = 16,
    parameter int OFFSET_BITS = 32,
    localparam int LEN_BITS   = $clog2(MAX_LENGTH + 1),
    localparam int IDX_BITS   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   scan,
    input  logic                   restart,
    input  logic                   clear,
    input  logic                   len_load,
    input  logic [LEN_BITS-1:0]    len_value,
    input  logic [MAX_LENGTH-1:0]  class_bits,
    input  logic [OFFSET_BITS-1:0] position,
    input  logic                   seen_in,
    input  logic [OFFSET_BITS-1:0] best_in,
    output logic                   seen_out,
    output logic [OFFSET_BITS-1:0] best_out
);
    logic [MAX_LENGTH-1:0]  partial_reg, partial_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [MAX_LENGTH-1:0]  step_vec;
    logic [OFFSET_BITS-1:0] start;
    logic                   hit;

    // Shift-and step and candidate start of this branch
    always_comb
    begin
        step_vec = ((partial_reg << 1) | MAX_LENGTH'(1)) & class_bits;
        start    = position + OFFSET_BITS'(1) - OFFSET_BITS'(len_reg);
        hit      = scan && (len_reg != '0) && step_vec[IDX_BITS'(len_reg - LEN_BITS'(1))]
                   && (!seen_in || (start < best_in));
        seen_out = seen_in | hit;
        best_out = hit ? start : best_in;
    end

    // Next vector and length
    always_comb
    begin
        if (restart)
        begin
            partial_next = '0;
        end
        else if (scan)
        begin
            partial_next = step_vec;
        end
        else
        begin
            partial_next = partial_reg;
        end

        if (clear)
        begin
            len_next = '0;
        end
        else if (len_load)
        begin
            len_next = len_value;
        end
        else
        begin
            len_next = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            len_reg     <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            len_reg     <= len_next;
        end
    end
endmodule

>>> hdl/multi_branch_class_matcher.sv
// Multi-branch class matcher top level: item stage, class store, row of branch cells, result register.
// A scan beat marked last is registered in the item stage, and its result then in the result register.
// Throughput: one beat per cycle; the class store read issued at acceptance sets the stage split.
// The input stalls only while a finished result waits and the next result is due.
// Reset clears all control state, lengths and scan state at once; the class store uses one
// valid flag per byte value, cleared by reset or a clear beat, so no clearing pass is needed.
module multi_branch_class_matcher import mbcm_pkg::*;
#(
    parameter int MAX_BRANCHES = 4,
    parameter int MAX_LENGTH   = 16,
    parameter int OFFSET_BITS  = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    mbcm_in_if.sink    item,
    mbcm_out_if.source result
);
    localparam int WORD_BITS = MAX_BRANCHES * MAX_LENGTH;
    localparam int LEN_BITS  = $clog2(MAX_LENGTH + 1);

    // Item stage
    logic                     s1_valid_reg, s1_valid_next;
    action_t                  s1_action_reg;
    logic [BYTE_BITS-1:0]     s1_byte_reg;
    logic                     s1_last_reg;
    logic [BRANCH_BITS-1:0]   s1_branch_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;
    logic [LENGTH_BITS-1:0]   s1_len_reg;

    logic in_fire, s1_go, s1_result, s1_stall;

    // Class store and write forwarding
    logic [BYTE_VALUES-1:0] valid_reg, valid_next;
    logic                   fwd_reg, fwd_next;
    logic [WORD_BITS-1:0]   fwd_data_reg;
    logic [WORD_BITS-1:0]   ram_rdata, entry, set_mask, wdata;
    logic [BYTE_BITS-1:0]   raddr;
    logic                   we;

    // Scan state
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] best_reg, best_next;
    logic                   seen_reg, seen_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg;
    logic [START_BITS-1:0] start_reg;

    // Cell controls
    logic                scan, restart, clear;
    logic [LEN_BITS-1:0] len_sat;
    logic                seen_chain [MAX_BRANCHES+1];
    logic [OFFSET_BITS-1:0] best_chain [MAX_BRANCHES+1];

    // Handshake and stage control
    always_comb
    begin
        s1_result     = (s1_action_reg == ACT_SCAN) && s1_last_reg;
        s1_stall      = s1_result && out_valid_reg && !result.ready;
        s1_go         = s1_valid_reg && !s1_stall;
        item.ready    = !s1_valid_reg || s1_go;
        in_fire       = item.valid && item.ready;
        s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        raddr         = in_fire ? item.data_byte : s1_byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= action_t'(item.action);
            s1_byte_reg   <= item.data_byte;
            s1_last_reg   <= item.last_byte;
            s1_branch_reg <= item.branch;
            s1_pos_reg    <= item.position_index;
            s1_len_reg    <= item.length;
        end
    end

    // Class store: one word per byte value, all branches side by side
    mbcm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BYTE_VALUES)
    ) u_class_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_byte_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Member bit to set; out-of-range branch or position selects nothing
    generate
        for (genvar b = 0; b < MAX_BRANCHES; b++)
        begin : g_mask_b
            for (genvar p = 0; p < MAX_LENGTH; p++)
            begin : g_mask_p
                assign set_mask[b*MAX_LENGTH + p] = (int'(s1_branch_reg) == b)
                                                 && (int'(s1_pos_reg) == p);
            end
        end
    endgenerate

    // Entry read: forwarded write, stored word, or zero when never written since clear
    always_comb
    begin
        if (fwd_reg)
        begin
            entry = fwd_data_reg;
        end
        else if (valid_reg[s1_byte_reg])
        begin
            entry = ram_rdata;
        end
        else
        begin
            entry = '0;
        end
        we       = s1_go && (s1_action_reg == ACT_MEMBER);
        wdata    = entry | set_mask;
        fwd_next = we && (raddr == s1_byte_reg);

        valid_next = valid_reg;
        if (s1_go && (s1_action_reg == ACT_CLEAR))
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[s1_byte_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    // Cell controls
    always_comb
    begin
        scan    = s1_go && (s1_action_reg == ACT_SCAN);
        clear   = s1_go && (s1_action_reg == ACT_CLEAR);
        restart = clear || (scan && s1_last_reg);
        len_sat = (int'(s1_len_reg) > MAX_LENGTH) ? LEN_BITS'(MAX_LENGTH)
                                                  : LEN_BITS'(s1_len_reg);
    end

    assign seen_chain[0] = seen_reg;
    assign best_chain[0] = best_reg;

    // Row of branch cells, best start handed along the row
    generate
        for (genvar b = 0; b < MAX_BRANCHES; b++)
        begin : g_cell
            mbcm_cell #(
                .MAX_LENGTH  (MAX_LENGTH),
                .OFFSET_BITS (OFFSET_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .scan       (scan),
                .restart    (restart),
                .clear      (clear),
                .len_load   (s1_go && (s1_action_reg == ACT_LENGTH)
                             && (int'(s1_branch_reg) == b)),
                .len_value  (len_sat),
                .class_bits (entry[b*MAX_LENGTH +: MAX_LENGTH]),
                .position   (pos_reg),
                .seen_in    (seen_chain[b]),
                .best_in    (best_chain[b]),
                .seen_out   (seen_chain[b+1]),
                .best_out   (best_chain[b+1])
            );
        end
    endgenerate

    // Scan state and result register
    always_comb
    begin
        if (restart)
        begin
            pos_next  = '0;
            best_next = '0;
            seen_next = 1'b0;
        end
        else if (scan)
        begin
            pos_next  = pos_reg + OFFSET_BITS'(1);
            best_next = best_chain[MAX_BRANCHES];
            seen_next = seen_chain[MAX_BRANCHES];
        end
        else
        begin
            pos_next  = pos_reg;
            best_next = best_reg;
            seen_next = seen_reg;
        end

        if (scan && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            best_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan && s1_last_reg)
        begin
            found_reg <= seen_chain[MAX_BRANCHES];
            start_reg <= seen_chain[MAX_BRANCHES]
                         ? START_BITS'(best_chain[MAX_BRANCHES]) : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.start_offset = start_reg;
endmodule
